// ===== hdl/cce_pkg.sv =====
package cce_pkg;

    localparam int VW = 30;
    localparam int DEF_RADIUS = 1;
    localparam int DEF_MAX_WIDTH = 1024;

    localparam logic [1:0] MODE_COEF  = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;

    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_DIVISOR = 2'd2;

    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_CONV,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic line_we;
        logic kern_we;
        logic start;
    } t_win_ctl;

endpackage

// ===== hdl/cce_window.sv =====
module cce_window #(
    parameter int KERNEL_RADIUS = cce_pkg::DEF_RADIUS,
    parameter int MAX_WIDTH = cce_pkg::DEF_MAX_WIDTH,
    localparam int SIDE = 2 * KERNEL_RADIUS + 1,
    localparam int TAPS = SIDE * SIDE,
    localparam int SW = $clog2(SIDE),
    localparam int KAW = $clog2(TAPS),
    localparam int LAW = $clog2(SIDE * MAX_WIDTH),
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int CW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cce_pkg::t_win_ctl            i_ctl,
    input  logic [LAW-1:0]               i_line_waddr,
    input  logic [7:0]                   i_line_wdata,
    input  logic [KAW-1:0]               i_kern_waddr,
    input  logic signed [15:0]           i_kern_wdata,
    input  logic [15:0]                  i_row,
    input  logic [SW-1:0]                i_slot,
    input  logic [XW-1:0]                i_col,
    input  logic [15:0]                  i_h,
    input  logic [CW-1:0]                i_w,
    output logic                         o_done,
    output logic signed [cce_pkg::VW-1:0] o_acc
);

    logic [7:0]         line_mem [SIDE*MAX_WIDTH];
    logic signed [15:0] kern_mem [TAPS];

    logic               r_busy;
    logic [SW-1:0]      r_ky;
    logic [SW-1:0]      r_kx;
    logic [KAW-1:0]     r_tap;
    logic               r_rv;
    logic               r_rlast;
    logic [7:0]         r_lq;
    logic signed [15:0] r_kq;
    logic signed [cce_pkg::VW-1:0] r_acc;
    logic               r_done;

    logic signed [17:0] y_raw;
    logic [15:0]        y_cl;
    logic signed [17:0] y_d;
    logic signed [4:0]  s_raw;
    logic [SW-1:0]      slot;
    logic signed [XW+1:0] x_raw;
    logic [XW-1:0]      x_cl;
    logic [XW-1:0]      w_last;
    logic [LAW-1:0]     raddr;
    logic signed [24:0] prod;

    always_comb begin
        y_raw = 18'({2'b00, i_row}) + 18'(r_ky) - 18'(KERNEL_RADIUS);
        if (y_raw[17]) begin
            y_cl = '0;
        end else if (y_raw > $signed({2'b00, i_h - 16'd1})) begin
            y_cl = i_h - 16'd1;
        end else begin
            y_cl = y_raw[15:0];
        end
        y_d = $signed({2'b00, y_cl}) - $signed({2'b00, i_row});
        s_raw = $signed(5'(i_slot)) + $signed(y_d[4:0]);
        if (s_raw < 0) begin
            s_raw = s_raw + 5'(SIDE);
        end else if (s_raw >= $signed(5'(SIDE))) begin
            s_raw = s_raw - 5'(SIDE);
        end
        slot = SW'(s_raw);
        w_last = XW'(i_w - CW'(1));
        x_raw = (XW+2)'({2'b00, i_col}) + (XW+2)'(r_kx) - (XW+2)'(KERNEL_RADIUS);
        if (x_raw[XW+1]) begin
            x_cl = '0;
        end else if (x_raw > $signed({2'b00, w_last})) begin
            x_cl = w_last;
        end else begin
            x_cl = x_raw[XW-1:0];
        end
        raddr = LAW'(int'(slot) * MAX_WIDTH + int'(x_cl));
        prod = $signed({1'b0, r_lq}) * r_kq;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.line_we) begin
            line_mem[i_line_waddr] <= i_line_wdata;
        end
        if (i_ctl.kern_we) begin
            kern_mem[i_kern_waddr] <= i_kern_wdata;
        end
        r_lq <= line_mem[raddr];
        r_kq <= kern_mem[r_tap];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_rv    <= 1'b0;
            r_done  <= 1'b0;
            r_ky    <= '0;
            r_kx    <= '0;
            r_tap   <= '0;
            r_rlast <= 1'b0;
        end else begin
            r_rv   <= r_busy;
            r_done <= r_rv && r_rlast;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_ky   <= '0;
                r_kx   <= '0;
                r_tap  <= '0;
            end else if (r_busy) begin
                r_rlast <= (r_tap == KAW'(TAPS - 1));
                if (r_tap == KAW'(TAPS - 1)) begin
                    r_busy <= 1'b0;
                end
                r_tap <= r_tap + KAW'(1);
                if (r_kx == SW'(SIDE - 1)) begin
                    r_kx <= '0;
                    r_ky <= r_ky + SW'(1);
                end else begin
                    r_kx <= r_kx + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc <= '0;
        end else if (r_rv) begin
            r_acc <= r_acc + cce_pkg::VW'(prod);
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// ===== hdl/cce_div.sv =====
module cce_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [cce_pkg::VW-1:0] i_num,
    input  logic [15:0]                   i_den,
    output logic                          o_done,
    output logic signed [cce_pkg::VW-1:0] o_quot
);

    localparam int NW = cce_pkg::VW;
    localparam int NCW = $clog2(NW + 1);

    logic            r_busy;
    logic [NCW-1:0]  r_cnt;
    logic [NW-1:0]   r_q;
    logic [15:0]     r_rem;
    logic [15:0]     r_den;
    logic            r_neg;
    logic            r_done;
    logic [16:0]     trial;
    logic [NW-1:0]   mag;

    always_comb begin
        trial = {r_rem, r_q[NW-1]};
        mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + NCW'(1);
                if (r_cnt == NCW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= mag;
            r_rem <= '0;
            r_den <= (i_den == 16'd0) ? 16'd1 : i_den;
            r_neg <= i_num[NW-1];
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                r_rem <= 16'(trial - {1'b0, r_den});
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= trial[15:0];
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

// ===== hdl/conv2d_clamp_edge_minmax_core.sv =====
// Streaming 2D convolution with clamp-to-edge borders over a raster frame held in a
// line memory of 2*KERNEL_RADIUS+1 rows. A coefficient word, an ignored word, a pixel
// past the last row or a drain tick that only restarts the frame releases no output. A
// pixel word releases at most KERNEL_RADIUS+1 outputs; for each one it runs the window
// reads (one line memory read and one kernel memory read per tap), then the bit-serial
// divider, then loads the output register and steps to the next column. A drain tick
// runs the window reads, the divider and the output load for its single output. An
// output that finds the output register still full waits there until the register is
// taken. The output register lets a finished word wait while the next input word is
// taken.
module conv2d_clamp_edge_minmax_core #(
    parameter int KERNEL_RADIUS = cce_pkg::DEF_RADIUS,
    parameter int MAX_WIDTH = cce_pkg::DEF_MAX_WIDTH,
    localparam int XW = $clog2(MAX_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_mode,
    input  logic [5:0]                    i_coef_index,
    input  logic signed [15:0]            i_coef_value,
    input  logic [7:0]                    i_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [cce_pkg::VW-1:0] o_out_value,
    output logic [15:0]                   o_out_row,
    output logic [XW-1:0]                 o_out_col,
    output logic signed [cce_pkg::VW-1:0] o_frame_min,
    output logic signed [cce_pkg::VW-1:0] o_frame_max,
    output logic                          o_last_of_run,
    output logic                          o_frame_end
);

    localparam int SIDE = 2 * KERNEL_RADIUS + 1;
    localparam int TAPS = SIDE * SIDE;
    localparam int SW = $clog2(SIDE);
    localparam int KAW = $clog2(TAPS);
    localparam int LAW = $clog2(SIDE * MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int NW = $clog2(KERNEL_RADIUS + 2);

    function automatic logic [SW-1:0] wrap_slot(input int s);
        int v;
        v = s;
        if (v >= SIDE) begin
            v = v - SIDE;
        end
        return SW'(v);
    endfunction

    cce_pkg::t_state r_state, n_state;

    logic [10:0] r_width;
    logic [15:0] r_height;
    logic [15:0] r_div;

    logic [15:0]   r_in_row;
    logic [CW-1:0] r_in_col;
    logic [SW-1:0] r_in_slot;
    logic [15:0]   r_emit_row;
    logic [CW-1:0] r_emit_col;
    logic [SW-1:0] r_emit_slot;
    logic signed [cce_pkg::VW-1:0] r_min, r_max;

    logic          r_drain;
    logic          r_run;
    logic          r_has;
    logic          r_last;
    logic [CW-1:0] r_ic;
    logic [CW-1:0] r_target;
    logic [NW-1:0] r_n;
    logic [XW-1:0] r_col;
    logic          r_win_start;
    logic signed [cce_pkg::VW-1:0] r_q;

    logic          r_out_valid;
    logic signed [cce_pkg::VW-1:0] r_out_value, r_out_min, r_out_max;
    logic [15:0]   r_out_row;
    logic [XW-1:0] r_out_col;
    logic          r_out_last, r_out_fend;

    logic [CW-1:0] w;
    logic [15:0]   h;
    logic          accept;
    logic          pix_ok;
    logic          drain_go;
    logic [CW-1:0] ic;
    logic          more;
    logic          out_free;
    logic          load_out;
    logic          win_go;
    logic          win_done, div_done;
    logic signed [cce_pkg::VW-1:0] win_acc, quot;
    logic signed [cce_pkg::VW-1:0] new_min, new_max;
    cce_pkg::t_win_ctl win_ctl;
    logic [LAW-1:0] line_waddr;
    logic [CW-1:0]  drain_col;

    always_comb begin
        if (r_width == 11'd0) begin
            w = CW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(r_width);
        end
        h = (r_height == 16'd0) ? 16'd1 : r_height;
        ic = (r_in_col >= w) ? w - CW'(1) : r_in_col;
        drain_col = (r_emit_col >= w) ? w - CW'(1) : r_emit_col;
        pix_ok = (r_in_row < h);
        drain_go = (r_in_row >= h) && (r_emit_row < h);
        more = r_run && r_has && (r_emit_col <= r_target) &&
               (r_n < NW'(KERNEL_RADIUS + 1));
        out_free = !r_out_valid || i_out_ready;
        load_out = (r_state == cce_pkg::S_EMIT) && out_free;
        new_min = (r_q < r_min) ? r_q : r_min;
        new_max = (r_q > r_max) ? r_q : r_max;
        line_waddr = LAW'(int'(r_in_slot) * MAX_WIDTH + int'(ic));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cce_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_mode == cce_pkg::MODE_PIXEL && pix_ok) begin
                        n_state = cce_pkg::S_NEXT;
                    end else if (i_mode == cce_pkg::MODE_DRAIN && drain_go) begin
                        n_state = cce_pkg::S_CONV;
                    end
                end
            end
            cce_pkg::S_NEXT: n_state = more ? cce_pkg::S_CONV : cce_pkg::S_IDLE;
            cce_pkg::S_CONV: if (win_done) n_state = cce_pkg::S_DIV;
            cce_pkg::S_DIV:  if (div_done) n_state = cce_pkg::S_EMIT;
            cce_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = r_drain ? cce_pkg::S_IDLE : cce_pkg::S_NEXT;
                end
            end
            default: n_state = cce_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == cce_pkg::S_IDLE);
        accept = i_in_valid && o_in_ready;
        win_go = ((r_state == cce_pkg::S_IDLE) && accept &&
                  (i_mode == cce_pkg::MODE_DRAIN) && drain_go) ||
                 ((r_state == cce_pkg::S_NEXT) && more);
        win_ctl.line_we = accept && (i_mode == cce_pkg::MODE_PIXEL) && pix_ok;
        win_ctl.kern_we = accept && (i_mode == cce_pkg::MODE_COEF) &&
                          (i_coef_index < 6'(TAPS));
        win_ctl.start = r_win_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cce_pkg::S_IDLE;
            r_width <= 11'd1024;
            r_height <= 16'd1024;
            r_div <= 16'd1;
            r_in_row <= '0;
            r_in_col <= '0;
            r_in_slot <= '0;
            r_emit_row <= '0;
            r_emit_col <= '0;
            r_emit_slot <= '0;
            r_min <= cce_pkg::VAL_MAX;
            r_max <= cce_pkg::VAL_MIN;
            r_win_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_drain <= 1'b0;
            r_run <= 1'b0;
            r_n <= '0;
        end else begin
            r_state <= n_state;
            r_win_start <= win_go;
            r_out_valid <= load_out || (r_out_valid && !i_out_ready);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    cce_pkg::CFG_WIDTH:   r_width <= i_cfg_data[10:0];
                    cce_pkg::CFG_HEIGHT:  r_height <= i_cfg_data;
                    cce_pkg::CFG_DIVISOR: r_div <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                cce_pkg::S_IDLE: begin
                    if (accept && i_mode == cce_pkg::MODE_PIXEL && pix_ok) begin
                        r_drain <= 1'b0;
                        r_ic <= ic;
                        r_last <= (32'(ic) + 1 >= 32'(w));
                        r_has <= (32'(ic) + 1 >= 32'(w)) || (32'(ic) >= KERNEL_RADIUS);
                        if (32'(ic) + 1 >= 32'(w)) begin
                            r_target <= w - CW'(1);
                        end else if (32'(ic) >= KERNEL_RADIUS) begin
                            r_target <= ic - CW'(KERNEL_RADIUS);
                        end else begin
                            r_target <= '0;
                        end
                        r_n <= '0;
                        if (32'(r_in_row) >= KERNEL_RADIUS) begin
                            r_run <= 1'b1;
                            r_emit_row <= r_in_row - 16'(KERNEL_RADIUS);
                            r_emit_slot <= wrap_slot(int'(r_in_slot) + KERNEL_RADIUS + 1);
                        end else begin
                            r_run <= 1'b0;
                        end
                    end else if (accept && i_mode == cce_pkg::MODE_DRAIN &&
                                 r_in_row >= h) begin
                        if (r_emit_row >= h) begin
                            r_in_row <= '0;
                            r_in_col <= '0;
                            r_in_slot <= '0;
                            r_emit_row <= '0;
                            r_emit_col <= '0;
                            r_emit_slot <= '0;
                            r_min <= cce_pkg::VAL_MAX;
                            r_max <= cce_pkg::VAL_MIN;
                        end else begin
                            r_drain <= 1'b1;
                            r_col <= XW'(drain_col);
                        end
                    end
                end
                cce_pkg::S_NEXT: begin
                    if (more) begin
                        r_col <= XW'(r_emit_col);
                    end else if (r_last) begin
                        r_in_row <= r_in_row + 16'd1;
                        r_in_col <= '0;
                        r_in_slot <= wrap_slot(int'(r_in_slot) + 1);
                        r_emit_col <= '0;
                        if (32'(r_in_row) + 1 > KERNEL_RADIUS) begin
                            r_emit_row <= r_in_row + 16'd1 - 16'(KERNEL_RADIUS);
                            r_emit_slot <= wrap_slot(int'(r_in_slot) + KERNEL_RADIUS + 2);
                        end
                    end else begin
                        r_in_col <= r_ic + CW'(1);
                    end
                end
                cce_pkg::S_CONV: ;
                cce_pkg::S_DIV: begin
                    if (div_done) begin
                        r_q <= quot;
                    end
                end
                cce_pkg::S_EMIT: begin
                    if (out_free) begin
                        r_out_value <= r_q;
                        r_out_row <= r_emit_row;
                        r_out_col <= r_col;
                        r_out_min <= new_min;
                        r_out_max <= new_max;
                        r_out_fend <= (r_emit_row == h - 16'd1) &&
                                      (CW'(r_col) == w - CW'(1));
                        if (r_drain) begin
                            r_out_last <= 1'b1;
                            if (CW'(r_col) + CW'(1) >= w) begin
                                r_emit_col <= '0;
                                if (r_emit_row + 16'd1 >= h) begin
                                    r_in_row <= '0;
                                    r_in_col <= '0;
                                    r_in_slot <= '0;
                                    r_emit_row <= '0;
                                    r_emit_slot <= '0;
                                    r_min <= cce_pkg::VAL_MAX;
                                    r_max <= cce_pkg::VAL_MIN;
                                end else begin
                                    r_emit_row <= r_emit_row + 16'd1;
                                    r_emit_slot <= wrap_slot(int'(r_emit_slot) + 1);
                                    r_min <= new_min;
                                    r_max <= new_max;
                                end
                            end else begin
                                r_emit_col <= CW'(r_col) + CW'(1);
                                r_min <= new_min;
                                r_max <= new_max;
                            end
                        end else begin
                            r_min <= new_min;
                            r_max <= new_max;
                            r_out_last <= (r_emit_col == r_target) ||
                                          (r_n == NW'(KERNEL_RADIUS));
                            r_emit_col <= r_emit_col + CW'(1);
                            r_n <= r_n + NW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    cce_window #(
        .KERNEL_RADIUS(KERNEL_RADIUS),
        .MAX_WIDTH(MAX_WIDTH)
    ) u_window (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl(win_ctl),
        .i_line_waddr(line_waddr),
        .i_line_wdata(i_pixel),
        .i_kern_waddr(KAW'(i_coef_index)),
        .i_kern_wdata(i_coef_value),
        .i_row(r_emit_row),
        .i_slot(r_emit_slot),
        .i_col(r_col),
        .i_h(h),
        .i_w(w),
        .o_done(win_done),
        .o_acc(win_acc)
    );

    cce_div u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(win_done),
        .i_num(win_acc),
        .i_den(r_div),
        .o_done(div_done),
        .o_quot(quot)
    );

    assign o_out_valid   = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_out_row     = r_out_row;
    assign o_out_col     = r_out_col;
    assign o_frame_min   = r_out_min;
    assign o_frame_max   = r_out_max;
    assign o_last_of_run = r_out_last;
    assign o_frame_end   = r_out_fend;

endmodule

// ===== test/conv2d_clamp_edge_minmax_core_tb.sv =====
`timescale 1ns / 1ps

module conv2d_clamp_edge_minmax_core_tb;

    localparam int RAD = 1;
    localparam int SIDE = 2 * RAD + 1;
    localparam int TAPS = SIDE * SIDE;
    localparam int MAXW = 1024;
    localparam int VW = cce_pkg::VW;
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef struct {
        logic [1:0] mode;
        logic [5:0] cidx;
        logic signed [15:0] cval;
        logic [7:0] pix;
    } t_word;

    typedef struct {
        logic signed [VW-1:0] value;
        logic [15:0] row;
        logic [9:0] col;
        logic signed [VW-1:0] vmin;
        logic signed [VW-1:0] vmax;
        logic last;
        logic fend;
    } t_pel;

    typedef struct {
        t_word w;
        bit typed;
        t_pel r;
    } t_drow;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [15:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic [1:0] i_mode;
    logic [5:0] i_coef_index;
    logic signed [15:0] i_coef_value;
    logic [7:0] i_pixel;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [VW-1:0] o_out_value;
    logic [15:0] o_out_row;
    logic [9:0] o_out_col;
    logic signed [VW-1:0] o_frame_min;
    logic signed [VW-1:0] o_frame_max;
    logic o_last_of_run;
    logic o_frame_end;

    conv2d_clamp_edge_minmax_core DUT (.*);

    // shadow state of the convolution
    logic [7:0] line_mem [SIDE*MAXW];
    logic signed [15:0] kern [TAPS];
    logic [10:0] reg_width;
    logic [15:0] reg_height;
    logic [15:0] reg_div;
    int in_row, in_col, emit_row, emit_col;
    longint run_min, run_max;

    t_pel pending_pels[$];
    t_pel burst[$];
    int n_fail;
    int snd_idle, rcv_idle;
    int hold_cycles;
    int n_words;

    function automatic int eff_w();
        return (reg_width < 1) ? 1 : (reg_width > MAXW) ? MAXW : int'(reg_width);
    endfunction

    function automatic int eff_h();
        return (reg_height < 1) ? 1 : int'(reg_height);
    endfunction

    function automatic void restart_frame();
        in_row = 0;
        in_col = 0;
        emit_row = 0;
        emit_col = 0;
        run_min = longint'(cce_pkg::VAL_MAX);
        run_max = longint'(cce_pkg::VAL_MIN);
    endfunction

    function automatic longint window_sum(int r, int c, int w, int h);
        longint acc;
        longint dv;
        int y, x;
        acc = 0;
        dv = (reg_div == 0) ? 1 : longint'(reg_div);
        for (int ky = 0; ky < SIDE; ky++) begin
            y = r + ky - RAD;
            if (y < 0) y = 0;
            if (y > h - 1) y = h - 1;
            for (int kx = 0; kx < SIDE; kx++) begin
                x = c + kx - RAD;
                if (x < 0) x = 0;
                if (x > w - 1) x = w - 1;
                acc += longint'(line_mem[(y % SIDE) * MAXW + x]) * longint'(kern[ky*SIDE+kx]);
            end
        end
        return acc / dv;
    endfunction

    function automatic void add_pel(int r, int c, int w, int h);
        longint v;
        t_pel p;
        v = window_sum(r, c, w, h);
        if (v < run_min) run_min = v;
        if (v > run_max) run_max = v;
        p.value = v[VW-1:0];
        p.row = r[15:0];
        p.col = c[9:0];
        p.vmin = run_min[VW-1:0];
        p.vmax = run_max[VW-1:0];
        p.last = 1'b0;
        p.fend = (r == h - 1 && c == w - 1);
        burst.push_back(p);
    endfunction

    function automatic void predict_word(t_word wd);
        int w, h, ic, r, tgt, c;
        bit last, has;
        w = eff_w();
        h = eff_h();
        burst.delete();
        case (wd.mode)
            cce_pkg::MODE_COEF: begin
                if (wd.cidx < TAPS) kern[wd.cidx] = wd.cval;
            end
            cce_pkg::MODE_PIXEL: begin
                if (in_row < h) begin
                    ic = (in_col >= w) ? w - 1 : in_col;
                    line_mem[(in_row % SIDE) * MAXW + ic] = wd.pix;
                    last = (ic + 1 >= w);
                    if (in_row >= RAD) begin
                        r = in_row - RAD;
                        has = last || ic >= RAD;
                        tgt = last ? w - 1 : (ic >= RAD ? ic - RAD : 0);
                        emit_row = r;
                        while (has && emit_col <= tgt && burst.size() < RAD + 1) begin
                            add_pel(r, emit_col, w, h);
                            emit_col++;
                        end
                    end
                    if (last) begin
                        in_row++;
                        in_col = 0;
                        emit_col = 0;
                        if (in_row > RAD) emit_row = in_row - RAD;
                    end else begin
                        in_col = ic + 1;
                    end
                end
            end
            cce_pkg::MODE_DRAIN: begin
                if (in_row >= h) begin
                    if (emit_row >= h) begin
                        restart_frame();
                    end else begin
                        c = (emit_col >= w) ? w - 1 : emit_col;
                        add_pel(emit_row, c, w, h);
                        if (c + 1 >= w) begin
                            emit_row++;
                            emit_col = 0;
                        end else begin
                            emit_col = c + 1;
                        end
                        if (emit_row >= h) restart_frame();
                    end
                end
            end
            default: ;
        endcase
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    endfunction

    task automatic send_word(t_word wd, bit typed, t_pel tr);
        if ($urandom_range(99) < snd_idle) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_mode <= wd.mode;
        i_coef_index <= wd.cidx;
        i_coef_value <= wd.cval;
        i_pixel <= wd.pix;
        do @(posedge i_clk); while (!o_in_ready);
        predict_word(wd);
        if (typed && burst.size() > 0) burst[burst.size()-1] = tr;
        foreach (burst[k]) pending_pels.push_back(burst[k]);
        n_words++;
    endtask

    task automatic send_plain(logic [1:0] m, logic [5:0] ci, logic signed [15:0] cv,
                              logic [7:0] px);
        t_word wd;
        t_pel none;
        wd = '{m, ci, cv, px};
        none = '{default: '0};
        send_word(wd, 1'b0, none);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_pels.size() != 0) @(posedge i_clk);
        repeat (60) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            cce_pkg::CFG_WIDTH: reg_width = val[10:0];
            cce_pkg::CFG_HEIGHT: reg_height = val;
            cce_pkg::CFG_DIVISOR: reg_div = val;
            default: ;
        endcase
    endtask

    task automatic run_frame(int w, int h, int dv, bit noisy);
        write_reg(cce_pkg::CFG_WIDTH, w[15:0]);
        write_reg(cce_pkg::CFG_HEIGHT, h[15:0]);
        write_reg(cce_pkg::CFG_DIVISOR, dv[15:0]);
        for (int k = 0; k < TAPS; k++) begin
            case ($urandom_range(5))
                0: send_plain(cce_pkg::MODE_COEF, k[5:0], 16'sh8000, 8'd0);
                1: send_plain(cce_pkg::MODE_COEF, k[5:0], 16'sh7fff, 8'd0);
                default: send_plain(cce_pkg::MODE_COEF, k[5:0], 16'($urandom), 8'd0);
            endcase
        end
        while (in_row < eff_h()) begin
            if (noisy && $urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: send_plain(MODE_NONE, 6'($urandom), 16'($urandom), 8'($urandom));
                    1: send_plain(cce_pkg::MODE_COEF, 6'($urandom_range(TAPS, 63)),
                                  16'($urandom), 8'($urandom));
                    2: send_plain(cce_pkg::MODE_COEF, 6'($urandom_range(TAPS - 1)),
                                  16'($urandom), 8'($urandom));
                    default: send_plain(cce_pkg::MODE_DRAIN, 6'($urandom), 16'($urandom),
                                        8'($urandom));
                endcase
            end
            send_plain(cce_pkg::MODE_PIXEL, 6'($urandom), 16'($urandom), 8'($urandom));
        end
        while (in_row >= eff_h()) begin
            if (noisy && $urandom_range(15) == 0)
                send_plain(cce_pkg::MODE_PIXEL, 6'($urandom), 16'($urandom), 8'($urandom));
            send_plain(cce_pkg::MODE_DRAIN, 6'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        t_pel e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pels.size() == 0) begin
                $error("unexpected output word row %0d col %0d", o_out_row, o_out_col);
                n_fail++;
            end else begin
                e = pending_pels.pop_front();
                if (o_out_value !== e.value) begin
                    $error("out_value exp %0d got %0d", e.value, o_out_value); n_fail++;
                end
                if (o_out_row !== e.row) begin
                    $error("out_row exp %0d got %0d", e.row, o_out_row); n_fail++;
                end
                if (o_out_col !== e.col) begin
                    $error("out_col exp %0d got %0d", e.col, o_out_col); n_fail++;
                end
                if (o_frame_min !== e.vmin) begin
                    $error("frame_min exp %0d got %0d", e.vmin, o_frame_min); n_fail++;
                end
                if (o_frame_max !== e.vmax) begin
                    $error("frame_max exp %0d got %0d", e.vmax, o_frame_max); n_fail++;
                end
                if (o_last_of_run !== e.last) begin
                    $error("last_of_run exp %0d got %0d", e.last, o_last_of_run); n_fail++;
                end
                if (o_frame_end !== e.fend) begin
                    $error("frame_end exp %0d got %0d", e.fend, o_frame_end); n_fail++;
                end
            end
        end
    end

    initial begin
        t_drow dir [$];
        t_pel nil;
        int w, h, dv;
        n_fail = 0;
        n_words = 0;
        hold_cycles = 0;
        snd_idle = 28;
        rcv_idle = 74;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = cce_pkg::CFG_WIDTH;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode = cce_pkg::MODE_COEF;
        i_coef_index = '0;
        i_coef_value = '0;
        i_pixel = '0;
        reg_width = 11'd1024;
        reg_height = 16'd1024;
        reg_div = 16'd1;
        foreach (line_mem[k]) line_mem[k] = '0;
        foreach (kern[k]) kern[k] = '0;
        restart_frame();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 2x2 frame, identity-like kernel with the largest center tap
        nil = '{default: '0};
        write_reg(cce_pkg::CFG_WIDTH, 16'd2);
        write_reg(cce_pkg::CFG_HEIGHT, 16'd2);
        write_reg(cce_pkg::CFG_DIVISOR, 16'd1);
        dir.push_back('{'{cce_pkg::MODE_COEF, 6'd0, 16'sh8000, 8'd0}, 1'b0, nil});
        dir.push_back('{'{cce_pkg::MODE_COEF, 6'd48, 16'sd1, 8'd0}, 1'b0, nil});
        dir.push_back('{'{cce_pkg::MODE_COEF, 6'd9, 16'sd5, 8'd0}, 1'b0, nil});
        for (int k = 0; k < TAPS; k++)
            dir.push_back('{'{cce_pkg::MODE_COEF, k[5:0], (k == 4) ? 16'sh7fff : 16'sd0,
                             8'd0}, 1'b0, nil});
        dir.push_back('{'{MODE_NONE, 6'd63, 16'shffff, 8'hff}, 1'b0, nil});
        dir.push_back('{'{cce_pkg::MODE_DRAIN, 6'd0, 16'sd0, 8'd0}, 1'b0, nil});
        dir.push_back('{'{cce_pkg::MODE_PIXEL, 6'd0, 16'sd0, 8'd255}, 1'b0, nil});
        dir.push_back('{'{cce_pkg::MODE_PIXEL, 6'd0, 16'sd0, 8'd0}, 1'b0, nil});
        dir.push_back('{'{cce_pkg::MODE_PIXEL, 6'd0, 16'sd0, 8'd0}, 1'b0, nil});
        dir.push_back('{'{cce_pkg::MODE_PIXEL, 6'd0, 16'sd0, 8'd255}, 1'b1,
                       '{30'sd0, 16'd0, 10'd1, 30'sd0, 30'sd8355585, 1'b1, 1'b0}});
        dir.push_back('{'{cce_pkg::MODE_PIXEL, 6'd0, 16'sd0, 8'd77}, 1'b0, nil});
        dir.push_back('{'{cce_pkg::MODE_DRAIN, 6'd0, 16'sd0, 8'd0}, 1'b1,
                       '{30'sd0, 16'd1, 10'd0, 30'sd0, 30'sd8355585, 1'b1, 1'b0}});
        dir.push_back('{'{cce_pkg::MODE_DRAIN, 6'd0, 16'sd0, 8'd0}, 1'b1,
                       '{30'sd8355585, 16'd1, 10'd1, 30'sd0, 30'sd8355585, 1'b1, 1'b1}});
        foreach (dir[k]) send_word(dir[k].w, dir[k].typed, dir[k].r);

        // extremes of the geometry registers
        write_reg(cce_pkg::CFG_HEIGHT, 16'hffff);
        run_frame(0, 3, 65535, 1'b0);

        n_words = 0;
        hold_cycles = 400;
        while (n_words < 370) begin
            if (n_words >= 123 && snd_idle == 28) begin
                snd_idle = 74;
                rcv_idle = 28;
            end else if (n_words >= 246 && snd_idle == 74) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            w = ($urandom_range(7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            h = $urandom_range(1, 5);
            case ($urandom_range(3))
                0: dv = 1;
                1: dv = $urandom_range(1, 300);
                2: dv = $urandom_range(1, 65535);
                default: dv = 256;
            endcase
            run_frame(w, h, dv, 1'b1);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_pels.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
